### hw/rtl/binary_min_heap_priority_queue_unit_assert.svh
// Assertion shorthands for the heap queue RTL (used by bmhpq_seq).
// Each one expects signals clk and rst_n in the scope where it is used.
`ifndef BINARY_MIN_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define BINARY_MIN_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BMHPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BMHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bmhpq_pkg.sv
package bmhpq_pkg;

  localparam int KEY_W = 32;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    status_t                 status;
  } rsp_t;

endpackage

### hw/rtl/bmhpq_ram.sv
module bmhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/bmhpq_seq.sv
`include "binary_min_heap_priority_queue_unit_assert.svh"

module bmhpq_seq
  import bmhpq_pkg::*;
#(
  parameter int CAPACITY = 1024,
  localparam int CNT_W = $clog2(CAPACITY + 1),
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  opcode_t                 req_op,
  input  logic signed [KEY_W-1:0] req_key,
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  output rsp_t                    rsp,
  output logic [CNT_W-1:0]        rsp_count,
  output logic                    mem_we,
  output logic [AW-1:0]           mem_waddr,
  output logic [KEY_W-1:0]        mem_wdata,
  output logic                    mem_re,
  output logic [AW-1:0]           mem_raddr,
  input  logic [KEY_W-1:0]        mem_rdata
);

  // Slot arithmetic is one-based and wide enough for a grandchild index.
  localparam int SW = CNT_W + 2;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CMP,
    S_UP_FIN,
    S_POP_TOP,
    S_POP_LAST,
    S_DN_L,
    S_DN_R,
    S_DN_FIN,
    S_RESP
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        pos_r, pos_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic signed [KEY_W-1:0] top_r, top_nxt;
  logic signed [KEY_W-1:0] lval_r, lval_nxt;
  logic                    lgo_r, lgo_nxt;
  status_t                 status_r, status_nxt;

  logic signed [KEY_W-1:0] rd_key;
  logic [SW-1:0]           pos_s, cnt_s, par_s, l_s, r_s, nxt_s, nxt_child_s, new_cnt_s;
  logic                    rgo, take_r;

  function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] slot);
    logic [SW-1:0] a;
    a = slot - SW'(1);
    return a[AW-1:0];
  endfunction

  assign rd_key      = $signed(mem_rdata);
  assign pos_s       = SW'(pos_r);
  assign cnt_s       = SW'(count_r);
  assign par_s       = pos_s >> 1;
  assign l_s         = pos_s << 1;
  assign r_s         = l_s | SW'(1);
  assign new_cnt_s   = cnt_s + SW'(1);
  assign rgo         = key_r > rd_key;
  // Prefer the right child unless the left one is strictly smaller.
  assign take_r      = rgo && !(lgo_r && (rd_key > lval_r));
  assign nxt_s       = take_r ? r_s : l_s;
  assign nxt_child_s = nxt_s << 1;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    key_nxt    = key_r;
    top_nxt    = top_r;
    lval_nxt   = lval_r;
    lgo_nxt    = lgo_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_waddr  = slot_addr(pos_s);
    mem_wdata  = key_r;
    mem_re     = 1'b0;
    mem_raddr  = slot_addr(SW'(1));

    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          key_nxt    = req_key;
          top_nxt    = '0;
          status_nxt = ST_OK;
          if (req_op == OP_PUSH) begin
            if (count_r == CAP_C) begin
              status_nxt = ST_FULL;
              state_nxt  = S_RESP;
            end else begin
              pos_nxt   = new_cnt_s[CNT_W-1:0];
              count_nxt = new_cnt_s[CNT_W-1:0];
              if (count_r != '0) begin
                mem_re    = 1'b1;
                mem_raddr = slot_addr(new_cnt_s >> 1);
                state_nxt = S_UP_CMP;
              end else begin
                state_nxt = S_UP_FIN;
              end
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_RESP;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = slot_addr(SW'(1));
              state_nxt = S_POP_TOP;
            end
          end
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (rd_key > key_r) begin
          // Pull the parent down into the hole and climb.
          mem_wdata = mem_rdata;
          pos_nxt   = par_s[CNT_W-1:0];
          if (par_s > SW'(1)) begin
            mem_re    = 1'b1;
            mem_raddr = slot_addr(par_s >> 1);
          end else begin
            state_nxt = S_UP_FIN;
          end
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_UP_FIN: begin
        mem_we    = 1'b1;
        state_nxt = S_RESP;
      end
      S_POP_TOP: begin
        top_nxt   = rd_key;
        mem_re    = 1'b1;
        mem_raddr = slot_addr(cnt_s);
        state_nxt = S_POP_LAST;
      end
      S_POP_LAST: begin
        key_nxt   = rd_key;
        count_nxt = count_r - CNT_W'(1);
        pos_nxt   = CNT_W'(1);
        if (cnt_s > SW'(2)) begin
          mem_re    = 1'b1;
          mem_raddr = slot_addr(SW'(2));
          state_nxt = S_DN_L;
        end else begin
          state_nxt = S_DN_FIN;
        end
      end
      S_DN_L: begin
        lval_nxt = rd_key;
        lgo_nxt  = key_r > rd_key;
        if (r_s <= cnt_s) begin
          mem_re    = 1'b1;
          mem_raddr = slot_addr(r_s);
          state_nxt = S_DN_R;
        end else if (key_r > rd_key) begin
          // Only a left child, and it is smaller: it moves up and the key takes its slot.
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          pos_nxt   = l_s[CNT_W-1:0];
          state_nxt = S_DN_FIN;
        end else begin
          mem_we    = 1'b1;
          state_nxt = S_RESP;
        end
      end
      S_DN_R: begin
        mem_we = 1'b1;
        if (!lgo_r && !rgo) begin
          state_nxt = S_RESP;
        end else begin
          mem_wdata = take_r ? mem_rdata : lval_r;
          pos_nxt   = nxt_s[CNT_W-1:0];
          if (nxt_child_s <= cnt_s) begin
            mem_re    = 1'b1;
            mem_raddr = slot_addr(nxt_child_s);
            state_nxt = S_DN_L;
          end else begin
            state_nxt = S_DN_FIN;
          end
        end
      end
      S_DN_FIN: begin
        mem_we    = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (rsp_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    key_r    <= key_nxt;
    top_r    <= top_nxt;
    lval_r   <= lval_nxt;
    lgo_r    <= lgo_nxt;
    status_r <= status_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  assign req_ready  = (state_r == S_IDLE);
  assign rsp_valid  = (state_r == S_RESP);
  assign rsp.key    = top_r;
  assign rsp.status = status_r;
  assign rsp_count  = count_r;

  `BMHPQ_ASSERT_NOW(a_no_rw_collide, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit the same slot")
  `BMHPQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CAP_C, "element count above capacity")
  `BMHPQ_ASSERT_NOW(a_full_flag, rsp_valid && (rsp.status == ST_FULL), count_r == CAP_C, "full status while not full")
  `BMHPQ_ASSERT_NEXT(a_push_count, req_valid && req_ready && (req_op == OP_PUSH) && (count_r != CAP_C), count_r == $past(count_r) + CNT_W'(1), "push did not grow the heap")

endmodule

### hw/rtl/binary_min_heap_priority_queue_unit.sv
// Binary min-heap priority queue of signed 32-bit keys held in one
// synchronous RAM of CAPACITY entries. Each input request either inserts a
// key (in_tuser = 0) or removes the smallest key held (in_tuser = 1); every
// request yields exactly one result carrying the removed key, a status code
// (ok, removal from an empty heap, insert dropped because the heap is full)
// and the occupancy after the request. Equal keys keep their place on the way
// up; on the way down, equal smaller children give way to the right one.
// Requests are served one at a time, and the heap RAM has a single read port
// with a registered read, which sets the timing. An insert reads the parent of
// the new slot (if any), pulls each strictly larger parent down one level as
// the key climbs, and writes the key into the hole. A removal reads the root,
// then the last key, and sinks that key by reading the left, then the right
// child at each level and moving the chosen child up; a lone left child is
// handled after the left read alone. Errors go straight to the result. The
// block returns to idle on the edge at which the previous result moves into
// the output register, so a new request is taken while the previous result
// still waits on out_tready. The RAM needs no clearing after reset: only
// slots below the occupancy are ever read.
module binary_min_heap_priority_queue_unit
  import bmhpq_pkg::*;
#(
  parameter int CAPACITY = 1024,
  localparam int CNT_W = $clog2(CAPACITY + 1),
  localparam int AW = $clog2(CAPACITY),
  localparam int OUT_TDATA_W = ((KEY_W + CNT_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [KEY_W-1:0]       in_tdata,   // [31:0] key_in
  input  logic                   in_tuser,   // [0] opcode
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [31:0] key_out, then occupancy, zero fill
  output logic [1:0]             out_tuser   // [1:0] status
);

  rsp_t             rsp;
  logic             rsp_valid, rsp_ready;
  logic [CNT_W-1:0] rsp_count;

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [KEY_W-1:0] mem_wdata, mem_rdata;

  // output register
  logic             out_valid_r, out_valid_nxt;
  rsp_t             out_rsp_r, out_rsp_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;

  bmhpq_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_op    (opcode_t'(in_tuser)),
    .req_key   ($signed(in_tdata)),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .rsp_count (rsp_count),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  bmhpq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Take a new result whenever the register is empty or being drained.
  assign rsp_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_rsp_nxt   = out_rsp_r;
    out_count_nxt = out_count_r;
    if (rsp_ready) begin
      out_valid_nxt = rsp_valid;
      if (rsp_valid) begin
        out_rsp_nxt   = rsp;
        out_count_nxt = rsp_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r   <= out_rsp_nxt;
    out_count_r <= out_count_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_count_r, out_rsp_r.key});
  assign out_tuser  = out_rsp_r.status;

endmodule

### tb/sv/tb.sv
module tb;
  import bmhpq_pkg::*;

  localparam int CAPACITY       = 1024;
  localparam int CNT_W          = $clog2(CAPACITY + 1);
  localparam int OUT_W          = ((KEY_W + CNT_W + 7) / 8) * 8;
  localparam int RX_HOLD_CYCLES = 400;   // long receiver hold-off for the backpressure test
  localparam int DRAIN_CYCLES   = 40;    // a bit more than the worst removal time
  localparam int RUN_LIMIT      = 20000000;

  // One expected result, field by field.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    status_t                 status;
    logic [CNT_W-1:0]        occupancy;
  } heap_result_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [KEY_W-1:0] in_tdata;   // [31:0] key_in
  logic             in_tuser;   // [0] opcode
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;  // [31:0] key_out, [42:32] occupancy, zero fill
  logic [1:0]       out_tuser;  // [1:0] status

  always #5 clk = ~clk;

  binary_min_heap_priority_queue_unit #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // ---------------------------------------------------------------------------
  // Heap predictor: a 1-based array in heap order plus a key count, updated
  // once per accepted request, in acceptance order.
  // ---------------------------------------------------------------------------
  logic signed [KEY_W-1:0] heap_keys [1:CAPACITY];
  int unsigned             heap_count;
  heap_result_t            pending_results[$];
  int unsigned             mismatch_count;

  // Knobs shared by the tests and the two handshake drivers.
  bit tx_idle_on;
  bit rx_idle_on;
  bit rx_hold_req;

  function automatic heap_result_t heap_apply(opcode_t op, logic signed [KEY_W-1:0] key);
    heap_result_t            res;
    logic signed [KEY_W-1:0] moving;
    int unsigned             pos, lc, rc, nxt, n;
    bit                      go_left, go_right;
    res.key    = '0;
    res.status = ST_OK;
    if (op == OP_PUSH) begin
      if (heap_count >= CAPACITY) begin
        // Full: drop the key, leave the heap alone.
        res.status = ST_FULL;
      end else begin
        // Climb past strictly larger parents only; an equal parent stays put.
        heap_count++;
        pos = heap_count;
        while (pos > 1 && heap_keys[pos / 2] > key) begin
          heap_keys[pos] = heap_keys[pos / 2];
          pos = pos / 2;
        end
        heap_keys[pos] = key;
      end
    end else if (heap_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      // Return the root, move the last key up and sink it.
      res.key = heap_keys[1];
      moving  = heap_keys[heap_count];
      heap_count--;
      n   = heap_count;
      pos = 1;
      while (1) begin
        lc       = 2 * pos;
        rc       = lc + 1;
        go_left  = (lc <= n) && (moving > heap_keys[lc]);
        go_right = (rc <= n) && (moving > heap_keys[rc]);
        if (!go_left && !go_right) break;
        // Equal smaller children: take the right one.
        if (go_right && !(go_left && heap_keys[rc] > heap_keys[lc])) nxt = rc;
        else nxt = lc;
        heap_keys[pos] = heap_keys[nxt];
        pos = nxt;
      end
      heap_keys[pos] = moving;
    end
    res.occupancy = heap_count[CNT_W-1:0];
    return res;
  endfunction

  // Mostly short gaps, some medium, a few long ones; zero means no gap.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mix full-range keys with a narrow band (to force equal keys) and extremes.
  function automatic logic signed [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom;
    if (r < 88) return $signed($urandom_range(0, 31)) - 16;
    if (r < 94) return 32'sh7FFF_FFFF;
    return 32'sh8000_0000;
  endfunction

  function automatic opcode_t pick_op(int push_pct);
    return ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: offer at the falling edge, hold until accepted at a rising
  // edge, then predict. Keep in_tvalid high across back-to-back requests.
  // ---------------------------------------------------------------------------
  task automatic send_request(opcode_t op, logic signed [KEY_W-1:0] key);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= key;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(heap_apply(op, key));
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop the request line and wait for every outstanding result.
  task automatic wait_results_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls, or one long hold-off when a test asks.
  // ---------------------------------------------------------------------------
  initial begin : result_receiver
    int stall;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        // Hold off long enough for the block to back up into its input.
        rx_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        stall = rx_idle_on ? pick_gap() : 0;
        if (stall == 0) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
        end
      end
    end
  end

  // Compare each accepted result against the oldest prediction.
  always @(posedge clk) begin : result_check
    heap_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: key %0d status %0d occupancy %0d",
                 $time, $signed(out_tdata[KEY_W-1:0]), out_tuser,
                 out_tdata[KEY_W +: CNT_W]);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[KEY_W-1:0] !== want.key) begin
          $display("%0t: key_out expected %0d actual %0d", $time, want.key,
                   $signed(out_tdata[KEY_W-1:0]));
          mismatch_count++;
        end
        if (out_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_tuser);
          mismatch_count++;
        end
        if (out_tdata[KEY_W +: CNT_W] !== want.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d", $time, want.occupancy,
                   out_tdata[KEY_W +: CNT_W]);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty removal, key extremes and alternating bit patterns, equal keys on the
  // way up, and equal smaller children on the way down.
  task automatic test_edge_keys();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_request(OP_POP, 32'shFFFF_FFFF);
    send_request(OP_PUSH, 32'sh7FFF_FFFF);
    send_request(OP_PUSH, 32'sh8000_0000);
    send_request(OP_PUSH, 32'sd0);
    send_request(OP_PUSH, -32'sd1);
    send_request(OP_PUSH, 32'sh5555_5555);
    send_request(OP_PUSH, 32'shAAAA_AAAA);
    send_request(OP_PUSH, 32'sd3);
    send_request(OP_PUSH, 32'sd3);
    repeat (8) send_request(OP_POP, 32'sd0);
    // Root 1 over two equal 5s: the moved 9 must go right.
    send_request(OP_PUSH, 32'sd1);
    send_request(OP_PUSH, 32'sd5);
    send_request(OP_PUSH, 32'sd5);
    send_request(OP_PUSH, 32'sd9);
    repeat (4) send_request(OP_POP, 32'sd0);
    wait_results_drained();
  endtask

  // Grow a deep heap back to back, then drain it with idling on and remove
  // once more from the empty heap.
  task automatic test_deep_heap();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (100) send_request(OP_PUSH, pick_key());
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    while (heap_count > 0) send_request(OP_POP, pick_key());
    send_request(OP_POP, 32'sd0);
    wait_results_drained();
  endtask

  // Random walk of the occupancy: grow first, then shrink back toward empty.
  task automatic test_random_mix();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (120) send_request(pick_op(62), pick_key());
    repeat (120) send_request(pick_op(38), pick_key());
    wait_results_drained();
  endtask

  // Hold the receiver off while requests keep coming, so in_tready must drop.
  task automatic test_backpressure();
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b1;
    rx_hold_req = 1'b1;
    repeat (24) send_request(pick_op(70), pick_key());
    wait_results_drained();
    tx_idle_on = 1'b1;
  endtask

  initial begin : test_sequence
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = 1'b0;
    heap_count     = 0;
    mismatch_count = 0;
    tx_idle_on     = 1'b0;
    rx_idle_on     = 1'b0;
    rx_hold_req    = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_edge_keys();
    test_deep_heap();
    test_random_mix();
    test_backpressure();

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: catches a hung handshake.
  initial begin : run_watchdog
    #(RUN_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/bmhpq_pkg.sv
hw/rtl/bmhpq_ram.sv
hw/rtl/bmhpq_seq.sv
hw/rtl/binary_min_heap_priority_queue_unit.sv
tb/sv/tb.sv
